>>> rtl/wcs_pkg.sv
// wcs_pkg: shared types and constants of the warning chime sequencer
// register indexes, reset values, configuration and queue handshake structs
// no dependencies
`default_nettype none

package wcs_pkg;

	localparam int unsigned CFG_IDX_W = 4;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned REP_W = 6;
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned QUIET_W = 20;
	localparam int unsigned SEG_LEN_W = 16;

	typedef logic [REP_W-1:0] rep_t;

	typedef enum logic [1:0] {
		OP_FRAME = 2'd0,
		OP_TICK  = 2'd1,
		OP_TEST  = 2'd2
	} opcode_t;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_MASK  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_QUIET_TICKS   = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_HALF    = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_HALF   = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_LEN     = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_GAP     = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_LEN    = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_GAP    = 4'd7;

	// reset values
	localparam logic [31:0] RST_TRIGGER_MASK = 32'hFFFF_FFFF;
	localparam logic [QUIET_W-1:0] RST_QUIET_TICKS = 20'd144000;
	localparam logic [SEG_LEN_W-1:0] RST_FIRST_HALF = 16'd6;
	localparam logic [SEG_LEN_W-1:0] RST_SECOND_HALF = 16'd4;
	localparam logic [SEG_LEN_W-1:0] RST_FIRST_LEN = 16'd1280;
	localparam logic [SEG_LEN_W-1:0] RST_INNER_GAP = 16'd560;
	localparam logic [SEG_LEN_W-1:0] RST_SECOND_LEN = 16'd1920;
	localparam logic [SEG_LEN_W-1:0] RST_REPEAT_GAP = 16'd1920;

	typedef struct packed {
		logic [31:0]          trigger_enable_mask;
		logic [QUIET_W-1:0]   quiet_ticks;
		logic [SEG_LEN_W-1:0] first_half_period;
		logic [SEG_LEN_W-1:0] second_half_period;
		logic [SEG_LEN_W-1:0] first_tone_length;
		logic [SEG_LEN_W-1:0] inner_gap_length;
		logic [SEG_LEN_W-1:0] second_tone_length;
		logic [SEG_LEN_W-1:0] repeat_gap_length;
	} cfg_t;

	typedef struct packed {
		logic push;
		rep_t push_data;
		logic pop;
	} q_ctrl_t;

	typedef struct packed {
		logic empty;
		logic full;
		rep_t head_data;
	} q_stat_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       sounding;
		logic                       busy;
	} seq_stat_t;

endpackage

`default_nettype wire

>>> rtl/wcs_in_if.sv
// wcs_in_if: input item channel of the warning chime sequencer
// no dependencies
`default_nettype none

interface wcs_in_if;
	logic                valid;
	logic                ready;
	logic [1:0]          opcode;
	logic [31:0]         warning_mask;
	logic                simulating;

	modport source (output valid, opcode, warning_mask, simulating, input ready);
	modport sink (input valid, opcode, warning_mask, simulating, output ready);
endinterface

`default_nettype wire

>>> rtl/wcs_out_if.sv
// wcs_out_if: result channel of the warning chime sequencer
// depends on wcs_pkg
`default_nettype none

interface wcs_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [wcs_pkg::SAMPLE_W-1:0] tone_sample;
	logic                                 sample_valid;
	logic                                 playing;
	logic [wcs_pkg::REP_W-1:0]           queued_repeats;
	logic                                 dropped;

	modport source (output valid, tone_sample, sample_valid, playing, queued_repeats, dropped,
		input ready);
	modport sink (input valid, tone_sample, sample_valid, playing, queued_repeats, dropped,
		output ready);
endinterface

`default_nettype wire

>>> rtl/wcs_cfg_if.sv
// wcs_cfg_if: configuration write channel, register index and write data
// depends on wcs_pkg
`default_nettype none

interface wcs_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [wcs_pkg::CFG_IDX_W-1:0]    index;
	logic [wcs_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/wcs_cfg_regs.sv
// wcs_cfg_regs: configuration register file, written through the cfg channel
// depends on wcs_pkg and wcs_cfg_if
`default_nettype none

module wcs_cfg_regs (
	input  wire logic          clk,
	input  wire logic          arst_n,
	wcs_cfg_if.sink            cfg,
	output wcs_pkg::cfg_t      regs
);

	wcs_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.trigger_enable_mask <= wcs_pkg::RST_TRIGGER_MASK;
			regs_q.quiet_ticks <= wcs_pkg::RST_QUIET_TICKS;
			regs_q.first_half_period <= wcs_pkg::RST_FIRST_HALF;
			regs_q.second_half_period <= wcs_pkg::RST_SECOND_HALF;
			regs_q.first_tone_length <= wcs_pkg::RST_FIRST_LEN;
			regs_q.inner_gap_length <= wcs_pkg::RST_INNER_GAP;
			regs_q.second_tone_length <= wcs_pkg::RST_SECOND_LEN;
			regs_q.repeat_gap_length <= wcs_pkg::RST_REPEAT_GAP;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				wcs_pkg::REG_TRIGGER_MASK: regs_q.trigger_enable_mask <= cfg.data;
				wcs_pkg::REG_QUIET_TICKS: regs_q.quiet_ticks <= cfg.data[wcs_pkg::QUIET_W-1:0];
				wcs_pkg::REG_FIRST_HALF: regs_q.first_half_period <= cfg.data[15:0];
				wcs_pkg::REG_SECOND_HALF: regs_q.second_half_period <= cfg.data[15:0];
				wcs_pkg::REG_FIRST_LEN: regs_q.first_tone_length <= cfg.data[15:0];
				wcs_pkg::REG_INNER_GAP: regs_q.inner_gap_length <= cfg.data[15:0];
				wcs_pkg::REG_SECOND_LEN: regs_q.second_tone_length <= cfg.data[15:0];
				wcs_pkg::REG_REPEAT_GAP: regs_q.repeat_gap_length <= cfg.data[15:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/wcs_event_queue.sv
// wcs_event_queue: fifo of pending chime events, each a repeat count
// depends on wcs_pkg
`default_nettype none

module wcs_event_queue #(
	parameter int unsigned QUEUE_DEPTH = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wcs_pkg::q_ctrl_t   ctrl,
	output wcs_pkg::q_stat_t   stat
);

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

	wcs_pkg::rep_t      mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   head_q;
	logic [PTR_W-1:0]   tail_q;
	logic [CNT_W-1:0]   count_q;

	assign stat.empty = (count_q == '0);
	assign stat.full = (count_q == FULL_CNT);
	assign stat.head_data = mem_q[head_q];

	// entries hold no reset, only the pointers and the count do
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			mem_q[tail_q] <= ctrl.push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
		end else begin
			if (ctrl.push) begin
				tail_q <= (tail_q == LAST_PTR) ? '0 : tail_q + 1'b1;
			end
			if (ctrl.pop) begin
				head_q <= (head_q == LAST_PTR) ? '0 : head_q + 1'b1;
			end
			if (ctrl.push && !ctrl.pop) begin
				count_q <= count_q + 1'b1;
			end else if (ctrl.pop && !ctrl.push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.push && !ctrl.pop |-> count_q != FULL_CNT)
		else $error("push into a full event queue");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.pop |-> count_q != '0)
		else $error("pop from an empty event queue");

endmodule

`default_nettype wire

>>> rtl/wcs_tone_seq.sv
// wcs_tone_seq: chime segment sequencer and square tone generator, one step per tick
// depends on wcs_pkg
`default_nettype none

module wcs_tone_seq #(
	parameter int unsigned AMPLITUDE = 24000
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          tick,
	input  wcs_pkg::cfg_t      cfg,
	input  wcs_pkg::q_stat_t   q_stat,
	output logic               pop,
	output wcs_pkg::seq_stat_t stat
);

	localparam int unsigned LW = wcs_pkg::SEG_LEN_W;
	localparam logic signed [wcs_pkg::SAMPLE_W-1:0] AMP_POS = wcs_pkg::SAMPLE_W'(AMPLITUDE);
	localparam logic signed [wcs_pkg::SAMPLE_W-1:0] AMP_NEG = -AMP_POS;

	typedef enum logic [2:0] {
		SEG_IDLE,
		SEG_TONE1,
		SEG_GAP1,
		SEG_TONE2,
		SEG_REPGAP
	} seg_t;

	typedef struct packed {
		seg_t          seg;
		wcs_pkg::rep_t rep;
	} walk_t;

	seg_t               segment_q;
	logic [LW-1:0]      seg_ticks_q;
	wcs_pkg::rep_t      repeats_q;
	logic [LW-1:0]      phase_q;
	logic               level_high_q;

	function automatic logic [LW-1:0] seg_len(seg_t s, wcs_pkg::cfg_t c);
		logic [LW-1:0] len;
		unique case (s)
			SEG_TONE1: len = c.first_tone_length;
			SEG_GAP1: len = c.inner_gap_length;
			SEG_TONE2: len = c.second_tone_length;
			SEG_REPGAP: len = c.repeat_gap_length;
			default: len = '0;
		endcase
		return len;
	endfunction

	function automatic walk_t next_seg(walk_t w);
		walk_t r;
		r = w;
		unique case (w.seg)
			SEG_TONE1: r.seg = SEG_GAP1;
			SEG_GAP1: r.seg = SEG_TONE2;
			SEG_TONE2: begin
				r.rep = (w.rep != '0) ? w.rep - 1'b1 : w.rep;
				r.seg = (r.rep != '0) ? SEG_REPGAP : SEG_IDLE;
			end
			SEG_REPGAP: r.seg = SEG_TONE1;
			default: r.seg = SEG_IDLE;
		endcase
		return r;
	endfunction

	// skip zero length segments; with all four empty every repeat is used up at once
	function automatic walk_t enter_seg(walk_t w, wcs_pkg::cfg_t c);
		walk_t r;
		logic  done;
		logic  all_zero;
		r = w;
		done = 1'b0;
		all_zero = (c.first_tone_length == '0) && (c.inner_gap_length == '0) &&
			(c.second_tone_length == '0) && (c.repeat_gap_length == '0);
		if (all_zero && w.seg != SEG_IDLE) begin
			r.seg = SEG_IDLE;
			r.rep = '0;
		end else begin
			for (int i = 0; i < 5; i++) begin
				if (!done) begin
					if (r.seg == SEG_IDLE || seg_len(r.seg, c) != '0) begin
						done = 1'b1;
					end else begin
						r = next_seg(r);
					end
				end
			end
		end
		return r;
	endfunction

	walk_t          cur_a;
	logic [LW-1:0]  ticks_a;
	logic [LW-1:0]  phase_a;
	logic           level_a;
	logic [LW-1:0]  half;
	logic [LW-1:0]  phase_b;
	logic           level_b;
	logic [LW-1:0]  ticks_b;
	walk_t          cur_n;
	logic [LW-1:0]  ticks_n;
	logic [LW-1:0]  phase_n;
	logic           level_n;
	logic           is_tone;

	always_comb begin
		pop = 1'b0;
		cur_a.seg = segment_q;
		cur_a.rep = repeats_q;
		ticks_a = seg_ticks_q;
		phase_a = phase_q;
		level_a = level_high_q;
		// an idle tick takes the next event and starts its first non-empty segment at once
		if (segment_q == SEG_IDLE && !q_stat.empty) begin
			pop = tick;
			cur_a.seg = SEG_TONE1;
			cur_a.rep = q_stat.head_data;
			cur_a = enter_seg(cur_a, cfg);
			ticks_a = seg_len(cur_a.seg, cfg);
			phase_a = '0;
			level_a = 1'b1;
		end

		is_tone = (cur_a.seg == SEG_TONE1) || (cur_a.seg == SEG_TONE2);
		half = (cur_a.seg == SEG_TONE1) ? cfg.first_half_period : cfg.second_half_period;
		if (half == '0) begin
			half = LW'(1);
		end
		phase_b = phase_a;
		level_b = level_a;
		if (is_tone) begin
			if (phase_a >= half) begin
				phase_b = '0;
				level_b = !level_a;
			end else begin
				phase_b = phase_a + 1'b1;
			end
		end

		stat.sounding = (cur_a.seg != SEG_IDLE);
		stat.busy = (segment_q != SEG_IDLE);
		stat.sample = '0;
		if (is_tone) begin
			stat.sample = level_b ? AMP_POS : AMP_NEG;
		end

		ticks_b = (ticks_a != '0) ? ticks_a - 1'b1 : ticks_a;
		cur_n = cur_a;
		ticks_n = ticks_b;
		phase_n = phase_b;
		level_n = level_b;
		if (cur_a.seg != SEG_IDLE && ticks_b == '0) begin
			cur_n = enter_seg(next_seg(cur_a), cfg);
			ticks_n = seg_len(cur_n.seg, cfg);
			phase_n = '0;
			level_n = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			segment_q <= SEG_IDLE;
			seg_ticks_q <= '0;
			repeats_q <= '0;
			phase_q <= '0;
			level_high_q <= 1'b1;
		end else if (tick) begin
			segment_q <= cur_n.seg;
			seg_ticks_q <= ticks_n;
			repeats_q <= cur_n.rep;
			phase_q <= phase_n;
			level_high_q <= level_n;
		end
	end

	a_active_seg_has_ticks: assert property (@(posedge clk) disable iff (!arst_n)
		segment_q != SEG_IDLE |-> seg_ticks_q != '0)
		else $error("active segment with no ticks left");

	a_pop_only_idle_tick: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> tick && segment_q == SEG_IDLE)
		else $error("event taken outside an idle tick");

endmodule

`default_nettype wire

>>> rtl/warning_chime_sequencer_top.sv
// warning_chime_sequencer_top: input register, frame edge detection, result register
// depends on wcs_pkg, wcs_in_if, wcs_out_if, wcs_cfg_if, wcs_cfg_regs,
// wcs_event_queue, wcs_tone_seq
//
// channel  direction  carries
// item     in         opcode, warning_mask, simulating
// result   out        tone_sample, sample_valid, playing, queued_repeats, dropped
// cfg      in         index, data (always ready)
//
// every item passes from transfer in to result out through the input register, then the result
// register; one item per cycle is sustained while the result side does not stall.
// the frame popcount and the segment step both sit between the two registers.
// a stalled result holds the result register; the input register still takes one item.
// reset clears all control state and loads the register defaults; no clearing pass.
`default_nettype none

module warning_chime_sequencer_top #(
	parameter int unsigned QUEUE_DEPTH = 8,
	parameter int unsigned MASK_WIDTH = 32,
	parameter int unsigned AMPLITUDE = 24000
) (
	input wire logic   clk,
	input wire logic   arst_n,
	wcs_in_if.sink     item,
	wcs_out_if.source  result,
	wcs_cfg_if.sink    cfg
);

	localparam int unsigned QW = wcs_pkg::QUIET_W;

	wcs_pkg::cfg_t      regs;
	wcs_pkg::q_ctrl_t   q_ctrl;
	wcs_pkg::q_stat_t   q_stat;
	wcs_pkg::seq_stat_t seq_stat;
	logic               seq_pop;

	// input register
	logic                   valid_s1;
	wcs_pkg::opcode_t       opcode_s1;
	logic [MASK_WIDTH-1:0]  mask_s1;
	logic                   sim_s1;

	// frame state
	logic [MASK_WIDTH-1:0]  prev_mask_q;
	logic                   was_sim_q;
	logic [QW-1:0]          elapsed_q;

	// result register
	logic                                 res_valid_q;
	logic signed [wcs_pkg::SAMPLE_W-1:0] res_sample_q;
	logic                                 res_sample_valid_q;
	logic                                 res_playing_q;
	wcs_pkg::rep_t                        res_queued_q;
	logic                                 res_dropped_q;

	logic                   advance;
	logic                   is_frame;
	logic                   is_tick;
	logic                   is_test;
	logic [MASK_WIDTH-1:0]  rise;
	wcs_pkg::rep_t          rise_cnt;
	logic                   frame_fires;
	logic                   push_req;
	wcs_pkg::rep_t          push_val;

	assign advance = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			opcode_s1 <= wcs_pkg::opcode_t'(item.opcode);
			mask_s1 <= item.warning_mask[MASK_WIDTH-1:0];
			sim_s1 <= item.simulating;
		end
	end

	assign is_frame = advance && (opcode_s1 == wcs_pkg::OP_FRAME);
	assign is_tick = advance && (opcode_s1 == wcs_pkg::OP_TICK);
	assign is_test = advance && (opcode_s1 == wcs_pkg::OP_TEST);

	always_comb begin
		rise = mask_s1 & ~prev_mask_q & regs.trigger_enable_mask[MASK_WIDTH-1:0];
		rise_cnt = '0;
		for (int i = 0; i < MASK_WIDTH; i++) begin
			rise_cnt = rise_cnt + wcs_pkg::REP_W'(rise[i]);
		end
	end

	// the first real frame after simulation only clears the flag
	assign frame_fires = !sim_s1 && !was_sim_q && (elapsed_q >= regs.quiet_ticks) &&
		(rise_cnt != '0);
	assign push_req = (is_frame && frame_fires) || is_test;
	assign push_val = is_test ? wcs_pkg::REP_W'(1) : rise_cnt;

	assign q_ctrl.push = push_req && !q_stat.full;
	assign q_ctrl.push_data = push_val;
	assign q_ctrl.pop = seq_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_mask_q <= '0;
			was_sim_q <= 1'b0;
			elapsed_q <= '0;
		end else begin
			if (is_frame) begin
				prev_mask_q <= mask_s1;
				was_sim_q <= sim_s1;
			end
			if (is_tick && elapsed_q < regs.quiet_ticks) begin
				elapsed_q <= elapsed_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_sample_q <= is_tick ? seq_stat.sample : '0;
			res_sample_valid_q <= is_tick;
			res_playing_q <= is_tick ? seq_stat.sounding : seq_stat.busy;
			res_queued_q <= q_ctrl.push ? push_val : '0;
			res_dropped_q <= push_req && q_stat.full;
		end
	end

	assign result.valid = res_valid_q;
	assign result.tone_sample = res_sample_q;
	assign result.sample_valid = res_sample_valid_q;
	assign result.playing = res_playing_q;
	assign result.queued_repeats = res_queued_q;
	assign result.dropped = res_dropped_q;

	wcs_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	wcs_event_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_event_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (q_ctrl),
		.stat   (q_stat)
	);

	wcs_tone_seq #(
		.AMPLITUDE (AMPLITUDE)
	) u_tone_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (is_tick),
		.cfg    (regs),
		.q_stat (q_stat),
		.pop    (seq_pop),
		.stat   (seq_stat)
	);

	a_result_follows_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res_valid_q)
		else $error("processed item left no result");

endmodule

`default_nettype wire
